### rtl/qdot_pkg.sv
// ----------------------------------------------------------------------------
// qdot_pkg
// Shared types, constants and float helpers for the Q4/Q8 block dot unit.
// ----------------------------------------------------------------------------
package qdot_pkg;

   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [3:0]  NIB_MASK  = 4'hF;
   localparam logic [4:0]  NIB_BIAS  = 5'd8;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DOT,
      ST_CONV,
      ST_MUL1A,
      ST_MUL1B,
      ST_MUL2A,
      ST_MUL2B,
      ST_ADDA,
      ST_ADDB,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        nan;
      logic        inf;
      logic        zero;
      logic        sign;
      logic [9:0]  exp;
      logic [47:0] prod;
   } mul_stage_type;

   typedef struct packed {
      logic        nan;
      logic        inf;
      logic        zero;
      logic        sign;
      logic [9:0]  exp;
      logic [27:0] sum;
   } add_stage_type;

   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] lz;
      logic       found;
      lz    = '0;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!found) begin
            if (v[i]) found = 1'b1;
            else      lz = lz + 5'd1;
         end
      end
      return lz;
   endfunction

   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0]  lz;
      logic [10:0] m;
      logic [31:0] r;
      if (h[14:10] == 5'h1F) begin
         r = {h[15], 8'hFF, h[9:0], 13'd0};
      end else if (h[14:10] != 5'd0) begin
         r = {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
      end else if (h[9:0] == 10'd0) begin
         r = {h[15], 31'd0};
      end else begin
         // subnormal half: normalize (leading zeros of 10-bit field)
         lz = lzc27({h[9:0], 17'd0});
         m  = {1'b0, h[9:0]} << (lz + 5'd1);
         r  = {h[15], 8'd112 - 8'(lz), m[9:0], 13'd0};
      end
      return r;
   endfunction

   function automatic logic [31:0] int_to_float(input logic signed [16:0] v);
      logic [16:0] mag;
      logic [4:0]  lz;
      logic [16:0] n;
      mag = v[16] ? 17'(-v) : 17'(v);
      lz  = lzc27({mag[15:0], 11'd0});
      n   = mag << lz;
      if (mag == 17'd0) return 32'd0;
      return {v[16], 8'd142 - 8'(lz), n[14:0], 8'd0};
   endfunction

   function automatic mul_stage_type mul_front(input logic [31:0] a, input logic [31:0] b);
      mul_stage_type r;
      logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_zero = (a[30:23] == 8'd0);
      b_zero = (b[30:23] == 8'd0);
      r.sign = a[31] ^ b[31];
      r.nan  = a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
      r.inf  = a_inf | b_inf;
      r.zero = a_zero | b_zero;
      r.exp  = 10'(a[30:23]) + 10'(b[30:23]) - 10'd127;
      r.prod = 48'({1'b1, a[22:0]}) * 48'({1'b1, b[22:0]});
      return r;
   endfunction

   function automatic logic [31:0] mul_back(input mul_stage_type s);
      logic [9:0]  e;
      logic [22:0] frac;
      logic        g, st, up;
      logic [30:0] packed_v;
      if (s.prod[47]) begin
         e = s.exp + 10'd1; frac = s.prod[46:24]; g = s.prod[23]; st = |s.prod[22:0];
      end else begin
         e = s.exp; frac = s.prod[45:23]; g = s.prod[22]; st = |s.prod[21:0];
      end
      up       = g & (st | frac[0]);
      packed_v = {e[7:0], frac} + 31'(up);
      if (s.nan)  return CANON_NAN;
      if (s.inf || e >= 10'd255 || packed_v[30:23] == 8'hFF) return {s.sign, 8'hFF, 23'd0};
      if (s.zero) return {s.sign, 31'd0};
      return {s.sign, packed_v};
   endfunction

   function automatic add_stage_type add_front(input logic [31:0] a, input logic [31:0] b);
      add_stage_type r;
      logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap;
      logic [31:0] big, sml;
      logic [7:0]  d;
      logic [26:0] mbx, bigx, al;
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      swap   = b[30:0] > a[30:0];
      big    = swap ? b : a;
      sml    = swap ? a : b;
      d      = big[30:23] - sml[30:23];
      bigx   = {(big[30:23] != 8'd0), big[22:0], 3'd0};
      mbx    = {(sml[30:23] != 8'd0), sml[22:0], 3'd0};
      if (d >= 8'd27) begin
         al = {26'd0, |mbx};
      end else begin
         al = (mbx >> d[4:0]) | {26'd0, |(mbx & ~(27'h7FF_FFFF << d[4:0]))};
      end
      if (a[31] == b[31]) r.sum = {1'b0, bigx} + {1'b0, al};
      else                r.sum = {1'b0, bigx} - {1'b0, al};
      r.exp  = 10'(big[30:23]);
      r.nan  = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
      r.inf  = a_inf | b_inf;
      r.zero = a_zero & b_zero;
      if (a_inf | b_inf)       r.sign = a_inf ? a[31] : b[31];
      else if (a_zero & b_zero) r.sign = a[31] & b[31];
      else                      r.sign = big[31];
      return r;
   endfunction

   function automatic logic [31:0] add_back(input add_stage_type s);
      logic [26:0] m;
      logic [9:0]  e;
      logic [4:0]  lz;
      logic        g, st, up;
      logic [30:0] packed_v;
      lz = lzc27(s.sum[26:0]);
      if (s.sum[27]) begin
         m = {s.sum[27:2], s.sum[1] | s.sum[0]};
         e = s.exp + 10'd1;
      end else begin
         m = s.sum[26:0] << lz;
         e = s.exp - 10'(lz);
      end
      g        = m[2];
      st       = m[1] | m[0];
      up       = g & (st | m[3]);
      packed_v = {e[7:0], m[25:3]} + 31'(up);
      if (s.nan)  return CANON_NAN;
      if (s.inf)  return {s.sign, 8'hFF, 23'd0};
      if (s.zero) return {s.sign, 31'd0};
      if (s.sum == 28'd0) return 32'd0;
      if (e >= 10'd255 || packed_v[30:23] == 8'hFF) return {s.sign, 8'hFF, 23'd0};
      return {s.sign, packed_v};
   endfunction

endpackage

### rtl/q4_q8_block_dot_accumulate_unit.sv
// ----------------------------------------------------------------------------
// q4_q8_block_dot_accumulate_unit
// Q4 x Q8 block dot product, scaled in fp32, accumulated per row in a RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time, from acceptance to the next acceptance:
// an integer dot product (eight products a cycle, then the sum is handed
// over), an int-to-float step, two fp32 multiplies and one fp32 add, each in
// a front and a back step through one shared multiplier and adder, a
// write-back step that updates the row entry in the accumulator RAM, and
// the idle state in which the next request is taken. Any block waits in
// write-back while a held response cannot be handed on, until it is taken.
// The RAM is read at acceptance and written at the end, so no two requests
// touch it at once. After reset a clearing pass writes zero to every entry,
// one per cycle, during which no request is taken. Requests for rows at or
// above ROWS are taken and dropped while idle. A response is produced on
// the last block of a row.
module q4_q8_block_dot_accumulate_unit #(
   parameter int ROWS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_weight_bytes_low,
   input  logic [63:0] req_weight_bytes_high,
   input  logic [15:0] req_weight_scale,
   input  logic [63:0] req_act_bytes_a,
   input  logic [63:0] req_act_bytes_b,
   input  logic [63:0] req_act_bytes_c,
   input  logic [63:0] req_act_bytes_d,
   input  logic [15:0] req_act_scale,
   input  logic [9:0]  req_row_index,
   input  logic        req_row_done,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_out_row,
   output logic [31:0] rsp_row_sum
);

   localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

   qdot_pkg::state_type state_ff, state_in;

   logic [AW-1:0]             clr_ff;
   logic [AW-1:0]             addr_ff;
   logic [9:0]                row_ff;
   logic                      last_ff;
   logic [31:0]               ws_ff;
   logic [31:0]               as_ff;
   logic [31:0]               x_ff;
   qdot_pkg::mul_stage_type   ms_ff;
   qdot_pkg::add_stage_type   ad_ff;
   logic                      rsp_valid_ff;
   logic [9:0]                rsp_row_ff;
   logic [31:0]               rsp_sum_ff;

   logic [16:0]               row_ext;
   logic                      in_range;
   logic                      accept;
   logic                      can_finish;
   logic                      finish;
   logic                      ram_wr_en;
   logic [AW-1:0]             ram_wr_addr;
   logic [31:0]               ram_wr_data;
   logic [31:0]               ram_rd_data;
   logic signed [16:0]        dot;
   logic                      dot_done;

   assign row_ext    = {7'd0, req_row_index};
   assign in_range   = row_ext < 17'(ROWS);
   assign can_finish = !(rsp_valid_ff && rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qdot_pkg::ST_CLEAR: if (clr_ff == AW'(ROWS - 1)) state_in = qdot_pkg::ST_IDLE;
         qdot_pkg::ST_IDLE:  if (req_valid && in_range) state_in = qdot_pkg::ST_DOT;
         qdot_pkg::ST_DOT:   if (dot_done) state_in = qdot_pkg::ST_CONV;
         qdot_pkg::ST_CONV:  state_in = qdot_pkg::ST_MUL1A;
         qdot_pkg::ST_MUL1A: state_in = qdot_pkg::ST_MUL1B;
         qdot_pkg::ST_MUL1B: state_in = qdot_pkg::ST_MUL2A;
         qdot_pkg::ST_MUL2A: state_in = qdot_pkg::ST_MUL2B;
         qdot_pkg::ST_MUL2B: state_in = qdot_pkg::ST_ADDA;
         qdot_pkg::ST_ADDA:  state_in = qdot_pkg::ST_ADDB;
         qdot_pkg::ST_ADDB:  state_in = qdot_pkg::ST_FINISH;
         qdot_pkg::ST_FINISH: if (can_finish) state_in = qdot_pkg::ST_IDLE;
         default:            state_in = qdot_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall   = 1'b1;
      accept      = 1'b0;
      finish      = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = last_ff ? 32'd0 : x_ff;
      case (state_ff)
         qdot_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = 32'd0;
         end
         qdot_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid && in_range;
         end
         qdot_pkg::ST_FINISH: begin
            finish    = can_finish;
            ram_wr_en = can_finish;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qdot_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == qdot_pkg::ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (finish && last_ff)   rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)     rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= row_ext[AW-1:0];
         row_ff  <= req_row_index;
         last_ff <= req_row_done;
         ws_ff   <= qdot_pkg::half_to_single(req_weight_scale);
         as_ff   <= qdot_pkg::half_to_single(req_act_scale);
      end
      case (state_ff)
         qdot_pkg::ST_CONV:  x_ff  <= qdot_pkg::int_to_float(dot);
         qdot_pkg::ST_MUL1A: ms_ff <= qdot_pkg::mul_front(x_ff, ws_ff);
         qdot_pkg::ST_MUL2A: ms_ff <= qdot_pkg::mul_front(x_ff, as_ff);
         qdot_pkg::ST_MUL1B,
         qdot_pkg::ST_MUL2B: x_ff  <= qdot_pkg::mul_back(ms_ff);
         qdot_pkg::ST_ADDA:  ad_ff <= qdot_pkg::add_front(ram_rd_data, x_ff);
         qdot_pkg::ST_ADDB:  x_ff  <= qdot_pkg::add_back(ad_ff);
         default: ;
      endcase
      if (finish && last_ff) begin
         rsp_row_ff <= row_ff;
         rsp_sum_ff <= x_ff;
      end
   end

   qdot_dotp u_dotp (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .weight ({req_weight_bytes_high, req_weight_bytes_low}),
      .act    ({req_act_bytes_d, req_act_bytes_c, req_act_bytes_b, req_act_bytes_a}),
      .dot    (dot),
      .done   (dot_done)
   );

   qdot_ram #(
      .WIDTH (32),
      .DEPTH (ROWS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (row_ext[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_row = rsp_row_ff;
   assign rsp_row_sum = rsp_sum_ff;

endmodule

### rtl/qdot_ram.sv
// ----------------------------------------------------------------------------
// qdot_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module qdot_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/qdot_dotp.sv
// ----------------------------------------------------------------------------
// qdot_dotp
// Integer block dot product: four weight bytes (eight products) per cycle.
// ----------------------------------------------------------------------------
module qdot_dotp (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [127:0]        weight,
   input  logic [255:0]        act,
   output logic signed [16:0]  dot,
   output logic                done
);

   logic [127:0]       w_ff;
   logic [255:0]       a_ff;
   logic [1:0]         cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic signed [16:0] dot_ff;
   logic signed [16:0] part_in;
   logic [31:0]        wsel;
   logic [31:0]        alo;
   logic [31:0]        ahi;

   always_comb begin
      logic signed [4:0]  lo, hi;
      logic signed [12:0] p0, p1;
      wsel    = w_ff[cnt_ff * 32 +: 32];
      alo     = a_ff[cnt_ff * 32 +: 32];
      ahi     = a_ff[128 + cnt_ff * 32 +: 32];
      part_in = '0;
      for (int i = 0; i < 4; i++) begin
         lo = $signed({1'b0, wsel[i*8 +: 4] & qdot_pkg::NIB_MASK}) - $signed(qdot_pkg::NIB_BIAS);
         hi = $signed({1'b0, wsel[i*8+4 +: 4]}) - $signed(qdot_pkg::NIB_BIAS);
         p0 = 13'(lo) * 13'($signed(alo[i*8 +: 8]));
         p1 = 13'(hi) * 13'($signed(ahi[i*8 +: 8]));
         part_in = part_in + 17'(p0) + 17'(p1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         w_ff   <= weight;
         a_ff   <= act;
         dot_ff <= '0;
      end else if (busy_ff) begin
         dot_ff <= dot_ff + part_in;
      end
   end

   assign dot  = dot_ff;
   assign done = done_ff;

endmodule

### rtl/qdot_checker.sv
// ----------------------------------------------------------------------------
// qdot_checker
// Port-level checks for the block dot accumulate unit, bound to the top.
// ----------------------------------------------------------------------------
module qdot_checker #(
   parameter int ROWS = 1024
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [9:0]  req_row_index,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [9:0]  rsp_out_row,
   input logic [31:0] rsp_row_sum
);

   // held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_row) && $stable(rsp_row_sum))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid && req_stall)
      else $error("activity right after reset");

   // an in-range request keeps the unit busy on the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && ({7'd0, req_row_index} < 17'(ROWS)) |=> req_stall)
      else $error("request taken while busy");

   a_no_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("response too early");

   a_canon_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_row_sum[30:23] == 8'hFF) && (rsp_row_sum[22:0] != 23'd0)
      |-> rsp_row_sum == 32'h7FC0_0000)
      else $error("non-canonical NaN");

endmodule

bind q4_q8_block_dot_accumulate_unit qdot_checker #(.ROWS(ROWS)) u_qdot_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_row_index (req_row_index),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_row   (rsp_out_row),
   .rsp_row_sum   (rsp_row_sum)
);

### verif/qdot_row_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdot_row_checker
// Watches both channels of the Q4/Q8 block dot unit. It keeps its own copy of
// the row accumulators, computes every finished row sum with exact fp32
// arithmetic and compares each response with the oldest expected one.
// ----------------------------------------------------------------------------
module qdot_row_checker #(
   parameter int ROWS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_weight_bytes_low,
   input  logic [63:0] req_weight_bytes_high,
   input  logic [15:0] req_weight_scale,
   input  logic [63:0] req_act_bytes_a,
   input  logic [63:0] req_act_bytes_b,
   input  logic [63:0] req_act_bytes_c,
   input  logic [63:0] req_act_bytes_d,
   input  logic [15:0] req_act_scale,
   input  logic [9:0]  req_row_index,
   input  logic        req_row_done,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [9:0]  rsp_out_row,
   input  logic [31:0] rsp_row_sum,
   output int          mismatch_count,
   output int          sums_outstanding
);

   typedef struct {
      logic [9:0]  row;
      logic [31:0] sum;
   } row_sum_type;

   typedef logic [299:0] wide_type;

   row_sum_type sums_due[$];
   logic [31:0] row_totals[ROWS];

   // Round m * 2^e to fp32, nearest-even, with subnormals and overflow.
   function automatic logic [31:0] fp32_pack(input logic s, input int e, input wide_type m);
      int       msb, sh, x;
      wide_type q, rem, half;
      msb = 0;
      if (m == '0) return {s, 31'd0};
      for (int i = 299; i >= 0; i--) begin
         if (m[i]) begin
            msb = i;
            break;
         end
      end
      sh = msb - 23;
      if (-149 - e > sh) sh = -149 - e;
      if (sh <= 0) begin
         q = m << (-sh);
      end else if (sh > 299) begin
         q = '0;
      end else begin
         q    = m >> sh;
         rem  = m & ((wide_type'(1) << sh) - 1);
         half = wide_type'(1) << (sh - 1);
         if (rem > half || (rem == half && q[0])) q = q + 1;
      end
      x = e + sh;
      if (q == (wide_type'(1) << 24)) begin
         q = q >> 1;
         x = x + 1;
      end
      if (q < (wide_type'(1) << 23)) return {s, q[30:0]};
      x = x + 150;
      if (x >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(x), q[22:0]};
   endfunction

   function automatic void fp32_split(input logic [31:0] f, output wide_type m, output int e);
      if (f[30:23] == 8'd0) begin
         m = wide_type'(f[22:0]);
         e = -149;
      end else begin
         m = wide_type'({1'b1, f[22:0]});
         e = int'(f[30:23]) - 150;
      end
   endfunction

   function automatic logic is_nan(input logic [31:0] f);
      return f[30:23] == 8'hFF && f[22:0] != 23'd0;
   endfunction

   function automatic logic is_inf(input logic [31:0] f);
      return f[30:23] == 8'hFF && f[22:0] == 23'd0;
   endfunction

   function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
      wide_type ma, mb;
      int       ea, eb;
      logic     s;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return qdot_pkg::CANON_NAN;
      if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
         return qdot_pkg::CANON_NAN;
      if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
      fp32_split(a, ma, ea);
      fp32_split(b, mb, eb);
      return fp32_pack(s, ea + eb, ma * mb);
   endfunction

   function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
      wide_type ma, mb;
      int       ea, eb, emin;
      if (is_nan(a) || is_nan(b)) return qdot_pkg::CANON_NAN;
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) return qdot_pkg::CANON_NAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      fp32_split(a, ma, ea);
      fp32_split(b, mb, eb);
      emin = (ea < eb) ? ea : eb;
      ma   = ma << (ea - emin);
      mb   = mb << (eb - emin);
      if (a[31] == b[31]) return fp32_pack(a[31], emin, ma + mb);
      if (ma > mb)        return fp32_pack(a[31], emin, ma - mb);
      if (mb > ma)        return fp32_pack(b[31], emin, mb - ma);
      return 32'd0;
   endfunction

   function automatic logic [31:0] half_widen(input logic [15:0] h);
      if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
      if (h[14:10] != 5'd0)  return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
      return fp32_pack(h[15], -24, wide_type'(h[9:0]));
   endfunction

   function automatic int block_dot(input logic [63:0] wl, input logic [63:0] wh,
                                    input logic [255:0] acts);
      logic [7:0] wb;
      int         acc;
      acc = 0;
      for (int j = 0; j < 16; j++) begin
         wb  = (j < 8) ? wl[8*j +: 8] : wh[8*(j-8) +: 8];
         acc += (int'(wb[3:0]) - 8) * int'($signed(acts[8*j +: 8]));
         acc += (int'(wb[7:4]) - 8) * int'($signed(acts[8*(j+16) +: 8]));
      end
      return acc;
   endfunction

   assign sums_outstanding = sums_due.size();

   always @(posedge clock) begin
      int          dot;
      logic [31:0] prod, total;
      row_sum_type want;
      if (reset) begin
         foreach (row_totals[i]) row_totals[i] = 32'd0;
         sums_due.delete();
         mismatch_count <= 0;
      end else begin
         if (req_valid && !req_stall && int'(req_row_index) < ROWS) begin
            dot = block_dot(req_weight_bytes_low, req_weight_bytes_high,
                            {req_act_bytes_d, req_act_bytes_c, req_act_bytes_b, req_act_bytes_a});
            prod = fp32_pack(dot < 0, 0, wide_type'(dot < 0 ? -dot : dot));
            prod = fp32_mul(prod, half_widen(req_weight_scale));
            prod = fp32_mul(prod, half_widen(req_act_scale));
            total = fp32_add(row_totals[req_row_index], prod);
            if (req_row_done) begin
               sums_due.push_back('{row: req_row_index, sum: total});
               row_totals[req_row_index] = 32'd0;
            end else begin
               row_totals[req_row_index] = total;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (sums_due.size() == 0) begin
               if (mismatch_count < 10)
                  $display("ERROR: unexpected response row=%0d sum=%h", rsp_out_row, rsp_row_sum);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = sums_due.pop_front();
               if (want.row !== rsp_out_row || want.sum !== rsp_row_sum) begin
                  if (mismatch_count < 10)
                     $display("ERROR: row exp=%0d got=%0d  sum exp=%h got=%h",
                              want.row, rsp_out_row, want.sum, rsp_row_sum);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random block requests into the Q4/Q8 dot unit with
// random gaps and response stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_weight_bytes_low = '0;
   logic [63:0] req_weight_bytes_high = '0;
   logic [15:0] req_weight_scale = '0;
   logic [63:0] req_act_bytes_a = '0;
   logic [63:0] req_act_bytes_b = '0;
   logic [63:0] req_act_bytes_c = '0;
   logic [63:0] req_act_bytes_d = '0;
   logic [15:0] req_act_scale = '0;
   logic [9:0]  req_row_index = '0;
   logic        req_row_done = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [9:0]  rsp_out_row;
   logic [31:0] rsp_row_sum;

   int mismatch_count;
   int sums_outstanding;
   int cycle_count = 0;
   bit no_idle = 1'b0;

   always #4 clock = ~clock;

   q4_q8_block_dot_accumulate_unit DUT (.*);
   qdot_row_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Response side: short random stalls, one long hold-off after a few sums.
   int stall_left = 0;
   int hold_left  = 0;
   int sums_taken = 0;
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end else if (rsp_valid && !rsp_stall) begin
         sums_taken <= sums_taken + 1;
         if (sums_taken == 40) begin
            hold_left <= 400;
            rsp_stall <= 1'b1;
         end else begin
            n = no_idle ? 0 : $urandom_range(0, 5);
            stall_left <= n;
            rsp_stall  <= (n > 0);
         end
      end
   end

   task automatic send_block(input logic [63:0] wl, input logic [63:0] wh,
                             input logic [15:0] ws, input logic [255:0] acts,
                             input logic [15:0] as, input logic [9:0] row,
                             input logic done);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_weight_bytes_low  <= wl;
      req_weight_bytes_high <= wh;
      req_weight_scale      <= ws;
      {req_act_bytes_d, req_act_bytes_c, req_act_bytes_b, req_act_bytes_a} <= acts;
      req_act_scale         <= as;
      req_row_index         <= row;
      req_row_done          <= done;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [255:0] rand_acts();
      return {rand64(), rand64(), rand64(), rand64()};
   endfunction

   // Mostly moderate normal scales, sometimes any half pattern at all.
   function automatic logic [15:0] rand_scale();
      if ($urandom_range(0, 99) < 85)
         return {1'($urandom), 5'($urandom_range(10, 20)), 10'($urandom)};
      return 16'($urandom);
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sums_outstanding != 0);
   endtask

   initial begin
      logic [9:0] row;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Extremes of the nibbles and activations, special half scales.
      send_block('0, '0, 16'h3C00, {32{8'h80}}, 16'h3C00, 10'd0, 1'b1);
      send_block('1, '1, 16'h3C00, {32{8'h80}}, 16'h3C00, 10'd1023, 1'b1);
      send_block('1, '1, 16'h7BFF, {32{8'h7F}}, 16'h7BFF, 10'd5, 1'b1);
      send_block('0, '0, 16'h0001, {32{8'h01}}, 16'h0001, 10'd6, 1'b1);
      send_block('0, '0, 16'h03FF, {32{8'h81}}, 16'h8200, 10'd7, 1'b0);
      send_block('1, '0, 16'h3C00, {32{8'h05}}, 16'h3C00, 10'd7, 1'b1);
      send_block('0, '0, 16'h7C00, {32{8'h01}}, 16'h3C00, 10'd8, 1'b1);
      send_block('0, '0, 16'hFC00, {32{8'h01}}, 16'h3C00, 10'd9, 1'b0);
      send_block('0, '0, 16'h7C00, {32{8'h01}}, 16'h3C00, 10'd9, 1'b1);
      send_block({8{8'h88}}, {8{8'h88}}, 16'h7C00, rand_acts(), 16'h3C00, 10'd10, 1'b1);
      send_block('0, '0, 16'h0000, {32{8'h01}}, 16'h7C00, 10'd11, 1'b1);
      send_block('0, '0, 16'h7E55, {32{8'h01}}, 16'h3C00, 10'd12, 1'b1);
      send_block('0, '0, 16'hFD01, {32{8'h01}}, 16'h3C00, 10'd13, 1'b1);
      send_block('0, '0, 16'h8000, {32{8'h01}}, 16'h3C00, 10'd14, 1'b1);
      send_block('0, '0, 16'h7BFF, {32{8'h80}}, 16'h7BFF, 10'd15, 1'b0);
      send_block('1, '1, 16'h7BFF, {32{8'h80}}, 16'h7BFF, 10'd15, 1'b1);
      send_block(rand64(), rand64(), 16'h3C00, rand_acts(), 16'h3C00, 10'd16, 1'b0);
      send_block(rand64(), rand64(), 16'h1000, rand_acts(), 16'h9000, 10'd16, 1'b1);
      send_block('1, '1, 16'hFFFF, '1, 16'hFFFF, 10'd1023, 1'b1);

      for (int i = 0; i < 1600; i++) begin
         if (i % 200 == 100) no_idle = 1'b1;
         if (i % 200 == 150) no_idle = 1'b0;
         if (i == 800) wait_drained();
         case ($urandom_range(0, 9))
            0:       row = 10'($urandom);
            1:       row = ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
            default: row = 10'($urandom_range(0, 15));
         endcase
         send_block(rand64(), rand64(), rand_scale(), rand_acts(), rand_scale(), row,
                    $urandom_range(0, 2) == 0);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/qdot_pkg.sv
rtl/qdot_ram.sv
rtl/qdot_dotp.sv
rtl/q4_q8_block_dot_accumulate_unit.sv
rtl/qdot_checker.sv
verif/qdot_row_checker.sv
verif/tb_top.sv
